@@ design/hbq_pkg.sv @@
// Shared types and constants for the stereo highpass biquad.
// Holds the word structs, coefficient set, lane status and fixed widths.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package hbq_pkg;

    localparam int CHANNEL_COUNT  = 2;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 22;
    localparam int COEF_BITS      = 26;
    localparam int CFG_INDEX_BITS = 2;

    // x - 2*x1 + x2 needs two bits of headroom over one sample
    localparam int DIFF_BITS = SAMPLE_BITS + 2;
    localparam int FF_BITS   = COEF_BITS + DIFF_BITS;
    localparam int FB_BITS   = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS  = FF_BITS + 2;
    localparam int RND_BITS  = ACC_BITS - COEF_FRAC_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] sample_word_t;
    typedef logic signed [COEF_BITS-1:0]   coef_word_t;

    localparam sample_word_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_word_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_FORWARD_GAIN = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_ONE = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_TWO = 2'd2;

    // Reset coefficients: 1 kHz cutoff at 48 kHz, Q3.22
    localparam coef_word_t GAIN_RESET = 26'sd3823491;
    localparam coef_word_t FB1_RESET  = -26'sd7614149;
    localparam coef_word_t FB2_RESET  = 26'sd3485549;

    typedef struct packed {
        sample_word_t sample_left;
        sample_word_t sample_right;
    } sample_t;

    typedef struct packed {
        sample_word_t filtered_left;
        sample_word_t filtered_right;
        logic         clipped;
    } result_t;

    typedef struct packed {
        coef_word_t forward_gain;
        coef_word_t feedback_one;
        coef_word_t feedback_two;
    } coef_set_t;

    typedef struct packed {
        sample_word_t y;
        logic         clip;
    } lane_out_t;

endpackage

@@ design/hbq_cfg.sv @@
// Coefficient register file for the stereo highpass biquad.
// Depends on hbq_pkg for the coefficient set and register indexes.
`timescale 1ns / 1ps

module hbq_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [hbq_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  hbq_pkg::coef_word_t                wr_data,
    output hbq_pkg::coef_set_t                 coefs
);
    import hbq_pkg::*;

    coef_set_t coefs_reg;
    coef_set_t coefs_next;

    always_comb
    begin
        coefs_next = coefs_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_FORWARD_GAIN: coefs_next.forward_gain = wr_data;
                REG_FEEDBACK_ONE: coefs_next.feedback_one = wr_data;
                REG_FEEDBACK_TWO: coefs_next.feedback_two = wr_data;
                default:          coefs_next = coefs_reg;  // unmapped index: drop
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.forward_gain <= GAIN_RESET;
            coefs_reg.feedback_one <= FB1_RESET;
            coefs_reg.feedback_two <= FB2_RESET;
        end
        else
        begin
            coefs_reg <= coefs_next;
        end
    end

    assign coefs = coefs_reg;

endmodule

@@ design/hbq_lane.sv @@
// One channel of the highpass biquad: history registers and the
// multiply-accumulate, round and saturate path. Depends on hbq_pkg.
`timescale 1ns / 1ps

module hbq_lane (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  hbq_pkg::sample_word_t x,
    input  hbq_pkg::coef_set_t    coefs,
    output hbq_pkg::lane_out_t    status
);
    import hbq_pkg::*;

    sample_word_t x1_reg, x2_reg, y1_reg, y2_reg;

    logic signed [DIFF_BITS-1:0] diff;
    logic signed [FF_BITS-1:0]   ff_prod;
    logic signed [FB_BITS-1:0]   fb1_prod;
    logic signed [FB_BITS-1:0]   fb2_prod;
    logic signed [ACC_BITS-1:0]  acc;
    logic signed [ACC_BITS-1:0]  acc_rnd;
    logic signed [RND_BITS-1:0]  y_wide;
    logic                        over_pos;
    logic                        over_neg;
    sample_word_t                y_sat;

    always_comb
    begin
        diff     = DIFF_BITS'(x) - (DIFF_BITS'(x1_reg) <<< 1) + DIFF_BITS'(x2_reg);
        ff_prod  = FF_BITS'(coefs.forward_gain) * FF_BITS'(diff);
        fb1_prod = FB_BITS'(coefs.feedback_one) * FB_BITS'(y1_reg);
        fb2_prod = FB_BITS'(coefs.feedback_two) * FB_BITS'(y2_reg);
        acc      = ACC_BITS'(ff_prod) - ACC_BITS'(fb1_prod) - ACC_BITS'(fb2_prod);
        // round half up, then drop the fraction bits
        acc_rnd  = acc + (ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1));
        y_wide   = RND_BITS'(acc_rnd >>> COEF_FRAC_BITS);
        over_pos = !y_wide[RND_BITS-1] && (|y_wide[RND_BITS-2:SAMPLE_BITS-1]);
        over_neg = y_wide[RND_BITS-1] && !(&y_wide[RND_BITS-2:SAMPLE_BITS-1]);
        priority if (over_pos)
            y_sat = SAMPLE_MAX;
        else if (over_neg)
            y_sat = SAMPLE_MIN;
        else
            y_sat = y_wide[SAMPLE_BITS-1:0];
    end

    // Advance the history only on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (advance)
        begin
            x2_reg <= x1_reg;
            x1_reg <= x;
            y2_reg <= y1_reg;
            y1_reg <= y_sat;
        end
    end

    assign status.y    = y_sat;
    assign status.clip = over_pos || over_neg;

endmodule

@@ design/stereo_highpass_biquad.sv @@
// Stereo highpass biquad: one lane per channel, merged into one result word.
// An accepted sample word shows at result_valid in the next cycle.
// Throughput: one word per cycle unless the output stalls; set by the lane's
// feedback loop: y1 of one word enters the next one's multiply-accumulate.
// Reset: coefficients return to the 1 kHz / 48 kHz set, all history is zero,
// and the output register is empty. Depends on hbq_pkg, hbq_cfg, hbq_lane.
`timescale 1ns / 1ps

module stereo_highpass_biquad (
    input  logic                               clk,
    input  logic                               rst_n,
    // sample words in
    input  logic                               sample_valid,
    output logic                               sample_ready,
    input  hbq_pkg::sample_t                   sample,
    // result words out
    output logic                               result_valid,
    input  logic                               result_ready,
    output hbq_pkg::result_t                   result,
    // coefficient writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hbq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  hbq_pkg::coef_word_t                cfg_data
);
    import hbq_pkg::*;

    coef_set_t    coefs;
    sample_word_t lane_x [CHANNEL_COUNT];
    lane_out_t    lane_status [CHANNEL_COUNT];
    logic         accept;
    logic         clip_any;

    logic    result_valid_reg;
    logic    result_valid_next;
    result_t result_reg;

    // cfg_ready is tied high; the host must write only while idle, unchecked.
    assign cfg_ready = 1'b1;

    hbq_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .coefs    (coefs)
    );

    // The output register doubles as the skid stage: take a new word whenever
    // it is empty or its word leaves in this same cycle.
    assign sample_ready = !result_valid_reg || result_ready;
    assign accept       = sample_valid && sample_ready;

    assign lane_x[0] = sample.sample_left;
    assign lane_x[1] = sample.sample_right;

    for (genvar ch = 0; ch < CHANNEL_COUNT; ch++)
    begin : g_lane
        hbq_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (accept),
            .x       (lane_x[ch]),
            .coefs   (coefs),
            .status  (lane_status[ch])
        );
    end

    // Merge: any lane that saturated flags the whole word
    always_comb
    begin
        clip_any = 1'b0;
        for (int ch = 0; ch < CHANNEL_COUNT; ch++)
            clip_any = clip_any | lane_status[ch].clip;
    end

    always_comb
    begin
        priority if (accept)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    // Payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg.filtered_left  <= lane_status[0].y;
            result_reg.filtered_right <= lane_status[1].y;
            result_reg.clipped        <= clip_any;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ design/hbq_checker.sv @@
// Port-level checks for the stereo highpass biquad, bound to the top level.
// Depends on hbq_pkg and on the port list of stereo_highpass_biquad.
`timescale 1ns / 1ps

module hbq_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_ready,
    input logic             result_valid,
    input logic             result_ready,
    input hbq_pkg::result_t result
);
    import hbq_pkg::*;

    // A stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // An empty output side never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> sample_ready)
        else $error("input blocked with empty output register");

    // Every accepted sample word shows a result on the next cycle
    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> result_valid)
        else $error("accepted word produced no result");

    // A clip flag comes only with a channel at a rail
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.clipped |->
            (result.filtered_left == SAMPLE_MAX || result.filtered_left == SAMPLE_MIN ||
             result.filtered_right == SAMPLE_MAX || result.filtered_right == SAMPLE_MIN))
        else $error("clip flag without a saturated channel");

endmodule

bind stereo_highpass_biquad hbq_checker u_hbq_checker (.*);

@@ sim/tb.sv @@
// Self-checking bench for the stereo highpass biquad: directed table, then random phases.
// Scores each result word against an in-bench fixed-point model of the two filter
// lanes, or a hand-typed expected word. Depends on hbq_pkg and stereo_highpass_biquad.
`timescale 1ns / 1ps

module tb;

    import hbq_pkg::*;

    localparam int  CLK_HALF_NS    = 2;
    localparam int  RESET_CYCLES   = 3;
    localparam int  RESULT_LATENCY = 1;
    localparam int  PHASES         = 6;
    localparam int  PHASE_WORDS    = 100;
    localparam int  IDLE_PERCENT   = 32;
    localparam int  TIMEOUT_NS     = 2_000_000;

    // The index port is two bits wide; the last code selects no register.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_t;

    // One step of the directed table: either a coefficient write or a
    // sample word, the latter optionally with a hand-typed expected result.
    typedef struct {
        row_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0] index;
        coef_word_t                data;
        sample_t                   word;
        bit                        typed;
        result_t                   want;
    } row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      sample_valid;
    logic                      sample_ready;
    sample_t                   sample;
    logic                      result_valid;
    logic                      result_ready;
    result_t                   result;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    coef_word_t                cfg_data;

    // Filter model state: coefficients and per-channel history.
    coef_word_t   gain_q;
    coef_word_t   fb_one_q;
    coef_word_t   fb_two_q;
    sample_word_t hist_x1 [CHANNEL_COUNT];
    sample_word_t hist_x2 [CHANNEL_COUNT];
    sample_word_t hist_y1 [CHANNEL_COUNT];
    sample_word_t hist_y2 [CHANNEL_COUNT];

    // Filtered words still owed by the block, oldest first.
    result_t pending_results [$];
    int      mismatch_count = 0;

    // Directed stimulus table, walked in order.
    row_t plan [$];

    // Suppress idling on both sides while set.
    bit steady = 1'b0;

    stereo_highpass_biquad uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // Run one stereo word through the model lanes and advance the history.
    // Sum the three products exactly, round half up, then clamp to 24 bits;
    // the clamped value is what feeds back as y1.
    function automatic result_t highpass_step(input sample_t word);
        sample_word_t xin  [CHANNEL_COUNT];
        sample_word_t yout [CHANNEL_COUNT];
        longint       diff;
        longint       acc;
        longint       rounded;
        result_t      r;
        xin[0]    = word.sample_left;
        xin[1]    = word.sample_right;
        r.clipped = 1'b0;
        for (int ch = 0; ch < CHANNEL_COUNT; ch++)
        begin
            diff = longint'(xin[ch]) - 2 * longint'(hist_x1[ch]) + longint'(hist_x2[ch]);
            acc  = longint'(gain_q) * diff
                 - longint'(fb_one_q) * longint'(hist_y1[ch])
                 - longint'(fb_two_q) * longint'(hist_y2[ch]);
            // arithmetic shift floors, so adding one half first rounds ties upward
            rounded = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
            if (rounded > longint'(SAMPLE_MAX))
            begin
                rounded   = longint'(SAMPLE_MAX);
                r.clipped = 1'b1;
            end
            else if (rounded < longint'(SAMPLE_MIN))
            begin
                rounded   = longint'(SAMPLE_MIN);
                r.clipped = 1'b1;
            end
            yout[ch]    = sample_word_t'(rounded);
            hist_x2[ch] = hist_x1[ch];
            hist_x1[ch] = xin[ch];
            hist_y2[ch] = hist_y1[ch];
            hist_y1[ch] = yout[ch];
        end
        r.filtered_left  = yout[0];
        r.filtered_right = yout[1];
        return r;
    endfunction

    function automatic void apply_coef(input logic [CFG_INDEX_BITS-1:0] index,
                                       input coef_word_t data);
        case (index)
            REG_FORWARD_GAIN: gain_q   = data;
            REG_FEEDBACK_ONE: fb_one_q = data;
            REG_FEEDBACK_TWO: fb_two_q = data;
            default:          ;  // no register behind this index
        endcase
    endfunction

    // Random sample level: mostly full-scale noise, some quiet audio, some rails and near-zero values.
    function automatic sample_word_t random_level();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return sample_word_t'($urandom);
        if (pick < 85)
            return sample_word_t'(int'($urandom_range(0, 4000)) - 2000);
        case ($urandom_range(4))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return sample_word_t'(0);
            3:       return sample_word_t'(1);
            default: return sample_word_t'(-1);
        endcase
    endfunction

    function automatic row_t sample_row(input sample_word_t left, input sample_word_t right);
        row_t row;
        row.kind               = ROW_SAMPLE;
        row.index              = REG_FORWARD_GAIN;
        row.data               = '0;
        row.word.sample_left   = left;
        row.word.sample_right  = right;
        row.typed              = 1'b0;
        row.want               = '0;
        return row;
    endfunction

    function automatic row_t typed_row(input sample_word_t left, input sample_word_t right,
                                       input sample_word_t want_left,
                                       input sample_word_t want_right, input logic want_clip);
        row_t row;
        row                     = sample_row(left, right);
        row.typed               = 1'b1;
        row.want.filtered_left  = want_left;
        row.want.filtered_right = want_right;
        row.want.clipped        = want_clip;
        return row;
    endfunction

    function automatic row_t cfg_row(input logic [CFG_INDEX_BITS-1:0] index,
                                     input coef_word_t data);
        row_t row;
        row       = sample_row('0, '0);
        row.kind  = ROW_WRITE;
        row.index = index;
        row.data  = data;
        return row;
    endfunction

    // Append one row to the end of the directed table.
    function automatic void add_row(input row_t row);
        plan.insert(plan.size(), row);
    endfunction

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Drop valid and hold until every owed result word has come back.
    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Offer one sample word, idling at random first. Valid stays high after
    // acceptance so back-to-back words never see a low-high glitch.
    task automatic send_sample(input sample_t word, input bit typed, input result_t want);
        result_t predicted;
        while (take_break())
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= word;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        // Advance the model even for typed rows so history stays in step.
        predicted = highpass_step(word);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    // Write one coefficient once the block is idle. Keep cfg_valid high when
    // another write follows right away.
    task automatic write_coef(input logic [CFG_INDEX_BITS-1:0] index, input coef_word_t data,
                              input bit hold);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_coef(index, data);
        if (!hold)
            cfg_valid <= 1'b0;
    endtask

    // Result side: score the word taken at each edge, then pick the next stall.
    initial
    begin
        result_t want;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result word", 0, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (result.filtered_left !== want.filtered_left)
                        report_mismatch("filtered_left", longint'(result.filtered_left),
                                        longint'(want.filtered_left));
                    if (result.filtered_right !== want.filtered_right)
                        report_mismatch("filtered_right", longint'(result.filtered_right),
                                        longint'(want.filtered_right));
                    if (result.clipped !== want.clipped)
                        report_mismatch("clipped", longint'(result.clipped),
                                        longint'(want.clipped));
                end
            end
            result_ready <= !take_break();
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("stereo_highpass_biquad regression: fail");
        $finish;
    end

    initial
    begin
        sample_t      word;
        coef_word_t   g;
        coef_word_t   f1;
        coef_word_t   f2;

        // Drive every input to a known value and hold reset.
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_FORWARD_GAIN;
        cfg_data     = '0;

        gain_q   = GAIN_RESET;
        fb_one_q = FB1_RESET;
        fb_two_q = FB2_RESET;
        for (int ch = 0; ch < CHANNEL_COUNT; ch++)
        begin
            hist_x1[ch] = '0;
            hist_x2[ch] = '0;
            hist_y1[ch] = '0;
            hist_y2[ch] = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Silence after reset must come out as silence.
        add_row(typed_row('0, '0, '0, '0, 1'b0));

        // Unity gain, no feedback: the output is the second difference of the
        // input, so the rails pass once and then overflow in both directions.
        add_row(cfg_row(REG_FORWARD_GAIN, coef_word_t'(1 << COEF_FRAC_BITS)));
        add_row(cfg_row(REG_FEEDBACK_ONE, '0));
        add_row(cfg_row(REG_FEEDBACK_TWO, '0));
        add_row(typed_row(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b0));
        add_row(typed_row(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b1));
        add_row(sample_row('0, '0));
        add_row(sample_row('0, '0));

        // Half gain on clean history: plus one half rounds up to one, minus one
        // half rounds up to zero.
        add_row(cfg_row(REG_FORWARD_GAIN, coef_word_t'(1 << (COEF_FRAC_BITS - 1))));
        add_row(typed_row(sample_word_t'(1), sample_word_t'(-1),
                          sample_word_t'(1), '0, 1'b0));
        add_row(sample_row(sample_word_t'(3), sample_word_t'(-3)));
        add_row(sample_row('0, '0));

        // Coefficients at opposite rails: saturating recursion.
        add_row(cfg_row(REG_FORWARD_GAIN, {1'b1, {(COEF_BITS-1){1'b0}}}));
        add_row(cfg_row(REG_FEEDBACK_ONE, {1'b0, {(COEF_BITS-1){1'b1}}}));
        add_row(cfg_row(REG_FEEDBACK_TWO, {1'b1, {(COEF_BITS-1){1'b0}}}));
        add_row(sample_row(SAMPLE_MAX, SAMPLE_MIN));
        add_row(sample_row(SAMPLE_MIN, SAMPLE_MAX));
        add_row(sample_row(SAMPLE_MAX, SAMPLE_MAX));
        add_row(sample_row('0, '0));
        add_row(sample_row(SAMPLE_MIN, SAMPLE_MIN));
        add_row(sample_row(sample_word_t'(-1), sample_word_t'(1)));

        add_row(cfg_row(REG_FORWARD_GAIN, {1'b0, {(COEF_BITS-1){1'b1}}}));
        add_row(cfg_row(REG_FEEDBACK_ONE, {1'b1, {(COEF_BITS-1){1'b0}}}));
        add_row(cfg_row(REG_FEEDBACK_TWO, {1'b0, {(COEF_BITS-1){1'b1}}}));
        add_row(sample_row(SAMPLE_MAX, SAMPLE_MAX));
        add_row(sample_row(SAMPLE_MIN, SAMPLE_MIN));
        add_row(sample_row('0, '0));
        add_row(sample_row(sample_word_t'(1), sample_word_t'(-1)));

        // A write to the spare index must leave every coefficient alone.
        add_row(cfg_row(REG_UNUSED, coef_word_t'($urandom)));
        add_row(sample_row(sample_word_t'(12345), sample_word_t'(-12345)));
        add_row(sample_row(sample_word_t'(-777), sample_word_t'(777)));

        // Back to the 1 kHz design and a few transients through it.
        add_row(cfg_row(REG_FORWARD_GAIN, GAIN_RESET));
        add_row(cfg_row(REG_FEEDBACK_ONE, FB1_RESET));
        add_row(cfg_row(REG_FEEDBACK_TWO, FB2_RESET));
        add_row(sample_row(SAMPLE_MAX, SAMPLE_MAX));
        add_row(sample_row('0, '0));
        add_row(sample_row(SAMPLE_MIN, sample_word_t'(-1)));
        add_row(sample_row('0, '0));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
                write_coef(plan[i].index, plan[i].data,
                           i + 1 < plan.size() && plan[i + 1].kind == ROW_WRITE);
            else
                send_sample(plan[i].word, plan[i].typed, plan[i].want);
        end

        // Random phases, each under its own coefficient set:
        //   design set, wild full-range sets, and small stable sets.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0, 4:
                begin
                    g  = GAIN_RESET;
                    f1 = FB1_RESET;
                    f2 = FB2_RESET;
                end
                1, 3:
                begin
                    g  = coef_word_t'($urandom);
                    f1 = coef_word_t'($urandom);
                    f2 = coef_word_t'($urandom);
                end
                default:
                begin
                    // |f1| + |f2| stays at or below one half, so the loop settles
                    g  = coef_word_t'(int'($urandom_range(0, 2 ** 24)) - (2 ** 23));
                    f1 = coef_word_t'(int'($urandom_range(0, 2 ** 21)) - (2 ** 20));
                    f2 = coef_word_t'(int'($urandom_range(0, 2 ** 21)) - (2 ** 20));
                end
            endcase
            write_coef(REG_FORWARD_GAIN, g, 1'b1);
            write_coef(REG_FEEDBACK_ONE, f1, 1'b1);
            write_coef(REG_FEEDBACK_TWO, f2, phase == 3);
            if (phase == 3)
                write_coef(REG_UNUSED, coef_word_t'($urandom), 1'b0);

            // One whole phase runs without any idling on either side.
            steady = (phase == 2);

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Halfway through phase 4, hold the sender until the block is empty.
                if (phase == 4 && n == PHASE_WORDS / 2)
                    wait_drained();
                word.sample_left  = random_level();
                word.sample_right = random_level();
                send_sample(word, 1'b0, '0);
            end
            steady = 1'b0;
        end

        wait_drained();
        repeat (RESULT_LATENCY + 4) @(posedge clk);

        if (mismatch_count == 0)
            $display("stereo_highpass_biquad regression: pass");
        else
            $display("stereo_highpass_biquad regression: fail");
        $finish;
    end

endmodule

@@ stereo_highpass_biquad.f @@
design/hbq_pkg.sv
design/hbq_cfg.sv
design/hbq_lane.sv
design/stereo_highpass_biquad.sv
design/hbq_checker.sv
sim/tb.sv
